[rtl/core/rbs_pkg.sv]
// Shared types and constants for the ray versus box slab intersection block.
// No dependencies.
package rbs_pkg;

    localparam int DVD_W = 48;
    localparam int DIV_LAT = DVD_W + 2;
    localparam int LANE_LAT = DIV_LAT + 1;
    localparam int TOP_LAT = LANE_LAT + 2;

    typedef logic signed [49:0] t_dist;

    localparam t_dist T_NEG_INF = {1'b1, 49'd0};
    localparam t_dist T_POS_INF = {1'b0, {49{1'b1}}};
    localparam t_dist DIST_MAX = 50'sh7FFF_FFFF;

    typedef struct packed {
        logic  act;
        logic  pmiss;
        t_dist tlo;
        t_dist thi;
    } t_lane_res;

endpackage

[rtl/core/rbs_div.sv]
// Pipelined signed divider giving floor(num * 65536 / den), one quotient bit a stage.
// Depends on rbs_pkg.
module rbs_div (
    input  logic                 i_clk,
    input  logic signed [32:0]   i_num,
    input  logic signed [31:0]   i_den,
    output rbs_pkg::t_dist       o_quo
);

    localparam int W = rbs_pkg::DVD_W;

    logic [31:0]  r_rem [0:W];
    logic [W-1:0] r_dvd [0:W];
    logic [31:0]  r_dn  [0:W-1];
    logic         r_neg [0:W];

    logic [31:0] n_an;
    logic [31:0] n_dn;

    always_comb begin
        n_an = i_num[32] ? 32'(-i_num) : 32'(i_num);
        n_dn = i_den[31] ? -i_den : i_den;
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_dvd[0] <= {n_an, 16'd0};
        r_dn[0]  <= n_dn;
        r_neg[0] <= i_num[32] ^ i_den[31];
    end

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [32:0] sh;
        logic        ge;
        logic [31:0] diff;
        always_comb begin
            sh   = {r_rem[k], r_dvd[k][W-1]};
            ge   = sh >= {1'b0, r_dn[k]};
            diff = sh[31:0] - r_dn[k];
        end
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= ge ? diff : sh[31:0];
            r_dvd[k+1] <= {r_dvd[k][W-2:0], ge};
            r_neg[k+1] <= r_neg[k];
        end
        if (k < W - 1) begin : g_dn
            always_ff @(posedge i_clk) begin
                r_dn[k+1] <= r_dn[k];
            end
        end
    end

    rbs_pkg::t_dist n_pos;

    always_comb begin
        n_pos = rbs_pkg::t_dist'({2'b00, r_dvd[W]});
    end

    always_ff @(posedge i_clk) begin
        if (r_neg[W]) begin
            o_quo <= -n_pos - ((r_rem[W] != '0) ? 50'sd1 : 50'sd0);
        end else begin
            o_quo <= n_pos;
        end
    end

endmodule

[rtl/core/rbs_lane.sv]
// One axis lane: two slab dividers, ordering of the pair and the parallel-slab test.
// Depends on rbs_pkg and rbs_div.
module rbs_lane (
    input  logic                 i_clk,
    input  logic signed [31:0]   i_c0,
    input  logic signed [31:0]   i_c1,
    input  logic signed [31:0]   i_p,
    input  logic signed [31:0]   i_d,
    output rbs_pkg::t_lane_res   o_res
);

    localparam int L = rbs_pkg::DIV_LAT;

    logic signed [32:0] n_na;
    logic signed [32:0] n_nb;
    logic               n_par;
    logic               n_pmiss;
    rbs_pkg::t_dist     ta;
    rbs_pkg::t_dist     tb;
    logic               r_par   [0:L-1];
    logic               r_pmiss [0:L-1];

    always_comb begin
        n_na    = 33'(i_c0) - 33'(i_p);
        n_nb    = 33'(i_c1) - 33'(i_p);
        n_par   = i_d == '0;
        n_pmiss = n_par && ((i_p < i_c0 && i_p < i_c1) || (i_p > i_c0 && i_p > i_c1));
    end

    rbs_div u_div_a (.i_clk(i_clk), .i_num(n_na), .i_den(i_d), .o_quo(ta));
    rbs_div u_div_b (.i_clk(i_clk), .i_num(n_nb), .i_den(i_d), .o_quo(tb));

    always_ff @(posedge i_clk) begin
        r_par[0]   <= n_par;
        r_pmiss[0] <= n_pmiss;
        for (int k = 1; k < L; k++) begin
            r_par[k]   <= r_par[k-1];
            r_pmiss[k] <= r_pmiss[k-1];
        end
        o_res.act   <= !r_par[L-1];
        o_res.pmiss <= r_pmiss[L-1];
        o_res.tlo   <= (ta < tb) ? ta : tb;
        o_res.thi   <= (ta < tb) ? tb : ta;
    end

endmodule

[rtl/core/rbs_merge.sv]
// Merging stage: combines the three lane results into hit flag and saturated distance.
// Depends on rbs_pkg.
module rbs_merge (
    input  logic                 i_clk,
    input  rbs_pkg::t_lane_res   i_x,
    input  rbs_pkg::t_lane_res   i_y,
    input  rbs_pkg::t_lane_res   i_z,
    output logic                 o_hit,
    output logic [30:0]          o_distance
);

    rbs_pkg::t_dist r_enter;
    rbs_pkg::t_dist r_leave;
    logic           r_miss;
    rbs_pkg::t_dist n_enter;
    rbs_pkg::t_dist n_leave;
    rbs_pkg::t_dist n_t;
    logic           n_miss;

    always_comb begin
        n_enter = rbs_pkg::T_NEG_INF;
        n_leave = rbs_pkg::T_POS_INF;
        if (i_x.act && i_x.tlo > n_enter) n_enter = i_x.tlo;
        if (i_y.act && i_y.tlo > n_enter) n_enter = i_y.tlo;
        if (i_z.act && i_z.tlo > n_enter) n_enter = i_z.tlo;
        if (i_x.act && i_x.thi < n_leave) n_leave = i_x.thi;
        if (i_y.act && i_y.thi < n_leave) n_leave = i_y.thi;
        if (i_z.act && i_z.thi < n_leave) n_leave = i_z.thi;
    end

    always_ff @(posedge i_clk) begin
        r_enter <= n_enter;
        r_leave <= n_leave;
        r_miss  <= i_x.pmiss | i_y.pmiss | i_z.pmiss;
    end

    always_comb begin
        n_miss = r_miss || r_leave < 0 || r_enter > r_leave;
        n_t    = (r_enter < 0) ? r_leave : r_enter;
        if (n_t > rbs_pkg::DIST_MAX) n_t = rbs_pkg::DIST_MAX;
    end

    always_ff @(posedge i_clk) begin
        o_hit      <= !n_miss;
        o_distance <= n_miss ? 31'd0 : n_t[30:0];
    end

endmodule

[rtl/core/ray_box_slab_intersection.sv]
// Ray versus axis-aligned box intersection by the slab method, three axis lanes.
// One request is taken every cycle; the 48-stage pipelined dividers in each lane set the depth.
// busy stays low; the receiver cannot stall, so each result shows for one cycle.
// Synchronous active-low reset clears the strobe pipeline only.
module ray_box_slab_intersection (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  i_box_min_x,
    input  logic signed [31:0]  i_box_min_y,
    input  logic signed [31:0]  i_box_min_z,
    input  logic signed [31:0]  i_box_max_x,
    input  logic signed [31:0]  i_box_max_y,
    input  logic signed [31:0]  i_box_max_z,
    input  logic signed [31:0]  i_origin_x,
    input  logic signed [31:0]  i_origin_y,
    input  logic signed [31:0]  i_origin_z,
    input  logic signed [31:0]  i_direction_x,
    input  logic signed [31:0]  i_direction_y,
    input  logic signed [31:0]  i_direction_z,
    output logic                o_strobe,
    output logic                o_hit,
    output logic [30:0]         o_distance
);

    localparam int LAT = rbs_pkg::TOP_LAT;

    rbs_pkg::t_lane_res lx;
    rbs_pkg::t_lane_res ly;
    rbs_pkg::t_lane_res lz;
    logic [LAT-1:0]     r_vld;

    assign busy     = 1'b0;
    assign o_strobe = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & !busy};
        end
    end

    rbs_lane u_lane_x (.i_clk(i_clk), .i_c0(i_box_min_x), .i_c1(i_box_max_x),
                       .i_p(i_origin_x), .i_d(i_direction_x), .o_res(lx));
    rbs_lane u_lane_y (.i_clk(i_clk), .i_c0(i_box_min_y), .i_c1(i_box_max_y),
                       .i_p(i_origin_y), .i_d(i_direction_y), .o_res(ly));
    rbs_lane u_lane_z (.i_clk(i_clk), .i_c0(i_box_min_z), .i_c1(i_box_max_z),
                       .i_p(i_origin_z), .i_d(i_direction_z), .o_res(lz));

    rbs_merge u_merge (.i_clk(i_clk), .i_x(lx), .i_y(ly), .i_z(lz),
                       .o_hit(o_hit), .o_distance(o_distance));

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_hit) |-> (o_distance == '0))
        else $error("miss result carries a nonzero distance");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##53 o_strobe)
        else $error("accepted request produced no result strobe");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_rst_n, LAT)) |-> $past(start, LAT))
        else $error("result strobe without a matching request");

endmodule

[tb/ray_box_slab_intersection_test.sv]
// Self-checking testbench for ray_box_slab_intersection: random and directed ray/box requests
// are checked against a slab-method predictor in this file.
// Depends on the block's RTL only.
`timescale 1ns / 100ps

module ray_box_slab_intersection_test;

    typedef struct {
        logic signed [31:0] bmin [3];
        logic signed [31:0] bmax [3];
        logic signed [31:0] org  [3];
        logic signed [31:0] dir  [3];
    } ray_query_t;

    typedef struct {
        logic        hit;
        logic [30:0] distance;
    } hit_result_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES = 80;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic signed [31:0] i_box_min_x, i_box_min_y, i_box_min_z;
    logic signed [31:0] i_box_max_x, i_box_max_y, i_box_max_z;
    logic signed [31:0] i_origin_x, i_origin_y, i_origin_z;
    logic signed [31:0] i_direction_x, i_direction_y, i_direction_z;
    logic        o_strobe;
    logic        o_hit;
    logic [30:0] o_distance;

    ray_query_t  pending_queries [$];
    hit_result_t expected_hits [$];
    int          mismatch_count;
    int          idle_cycles;
    int          quiet_cycles;
    bit          idle_allowed;
    bit          hold_for_drain;
    bit          stimulus_done;

    ray_box_slab_intersection i_dut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_box_min_x, .i_box_min_y, .i_box_min_z,
        .i_box_max_x, .i_box_max_y, .i_box_max_z,
        .i_origin_x, .i_origin_y, .i_origin_z,
        .i_direction_x, .i_direction_y, .i_direction_z,
        .o_strobe, .o_hit, .o_distance
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint floor_slab(longint num, longint den);
        longint scaled;
        longint quo;
        longint rem;
        scaled = num * 65536;
        quo = scaled / den;
        rem = scaled % den;
        if (rem != 0 && ((rem < 0) != (den < 0)))
            quo = quo - 1;
        return quo;
    endfunction

    function automatic hit_result_t predict_hit(ray_query_t q);
        hit_result_t res;
        longint entry_t, exit_t, lo, hi, ta, tb, t;
        bit missed;
        entry_t = -(64'sd1 <<< 62);
        exit_t = 64'sd1 <<< 62;
        missed = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (q.dir[a] == 0) begin
                lo = (q.bmin[a] < q.bmax[a]) ? q.bmin[a] : q.bmax[a];
                hi = (q.bmin[a] < q.bmax[a]) ? q.bmax[a] : q.bmin[a];
                if (longint'(q.org[a]) < lo || longint'(q.org[a]) > hi)
                    missed = 1'b1;
            end else begin
                ta = floor_slab(longint'(q.bmin[a]) - q.org[a], q.dir[a]);
                tb = floor_slab(longint'(q.bmax[a]) - q.org[a], q.dir[a]);
                if ((ta < tb ? ta : tb) > entry_t)
                    entry_t = ta < tb ? ta : tb;
                if ((ta < tb ? tb : ta) < exit_t)
                    exit_t = ta < tb ? tb : ta;
            end
        end
        if (exit_t < 0 || entry_t > exit_t)
            missed = 1'b1;
        if (missed) begin
            res.hit = 1'b0;
            res.distance = '0;
        end else begin
            t = entry_t < 0 ? exit_t : entry_t;
            if (t > 64'sh7FFF_FFFF)
                t = 64'sh7FFF_FFFF;
            res.hit = 1'b1;
            res.distance = t[30:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic logic [31:0] random_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            2: return {$urandom} & 32'hFFFF_0000;
            default: return 32'($signed($urandom_range(0, 400)) - 200) <<< 16;
        endcase
    endfunction

    function automatic ray_query_t random_query();
        ray_query_t q;
        int mode;
        mode = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++) begin
            if (mode < 6) begin
                // Moderate values: corners and origin on a coarse grid, box in either order, random or zero direction.
                q.bmin[a] = random_coord(3);
                q.bmax[a] = q.bmin[a] + random_coord(3) * (($urandom_range(0, 3) == 0) ? -1 : 1);
                q.org[a] = random_coord(3);
                q.dir[a] = ($urandom_range(0, 7) == 0) ? 32'sd0 : random_coord(1);
            end else begin
                q.bmin[a] = random_coord(mode % 3);
                q.bmax[a] = random_coord(mode % 3);
                q.org[a] = random_coord(mode % 3);
                q.dir[a] = ($urandom_range(0, 5) == 0) ? 32'sd0 : random_coord(mode % 3);
            end
        end
        return q;
    endfunction

    function automatic ray_query_t make_query(logic signed [31:0] bmn, logic signed [31:0] bmx,
                                              logic signed [31:0] o, logic signed [31:0] d);
        ray_query_t q;
        for (int a = 0; a < 3; a++) begin
            q.bmin[a] = bmn;
            q.bmax[a] = bmx;
            q.org[a] = o;
            q.dir[a] = d;
        end
        return q;
    endfunction

    initial begin
        ray_query_t q;
        localparam logic signed [31:0] ONE = 32'sh0001_0000;
        localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
        localparam logic signed [31:0] MINV = 32'sh8000_0000;
        i_rst_n = 1'b0;
        mismatch_count = 0;
        idle_allowed = 1'b0;
        hold_for_drain = 1'b0;
        stimulus_done = 1'b0;
        // Directed: hit from outside, origin inside, miss behind, parallel cases,
        // swapped corners, extremes and saturation.
        pending_queries.push_back(make_query(ONE, 2 * ONE, 0, ONE));
        pending_queries.push_back(make_query(-ONE, ONE, 0, ONE));
        pending_queries.push_back(make_query(ONE, 2 * ONE, 3 * ONE, ONE));
        pending_queries.push_back(make_query(2 * ONE, ONE, 0, -ONE));
        pending_queries.push_back(make_query(2 * ONE, ONE, 0, ONE));
        pending_queries.push_back(make_query(-ONE, ONE, 0, 0));
        pending_queries.push_back(make_query(ONE, 2 * ONE, 0, 0));
        pending_queries.push_back(make_query(ONE, ONE, ONE, 0));
        pending_queries.push_back(make_query(MINV, MAXV, 0, 1));
        pending_queries.push_back(make_query(MAXV, MAXV, MINV, 1));
        pending_queries.push_back(make_query(MINV, MAXV, MINV, MAXV));
        pending_queries.push_back(make_query(MINV, MINV, MAXV, MINV));
        pending_queries.push_back(make_query(MAXV, MINV, 0, -1));
        pending_queries.push_back(make_query(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 3));
        pending_queries.push_back(make_query(ONE, 3 * ONE, 0, 3));
        pending_queries.push_back(make_query(ONE, 3 * ONE, 0, -7));
        q = make_query(ONE, 2 * ONE, 0, ONE);
        q.dir[1] = 0;
        q.org[1] = 3 * ONE / 2;
        pending_queries.push_back(q);
        q.org[2] = 5 * ONE;
        pending_queries.push_back(q);
        q = make_query(-5 * ONE, 5 * ONE, 0, ONE);
        q.dir[0] = -ONE;
        q.dir[2] = 32'sh0000_8000;
        pending_queries.push_back(q);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_allowed = 1'b1;
        for (int n = 0; n < 700; n++) begin
            if (n == 350) begin
                wait (pending_queries.size() == 0);
                hold_for_drain = 1'b1;
                wait (expected_hits.size() == 0);
                @(posedge i_clk);
                hold_for_drain = 1'b0;
            end
            if (n == 600)
                idle_allowed = 1'b0;
            pending_queries.push_back(random_query());
            if (pending_queries.size() > 32)
                @(posedge i_clk);
        end
        wait (pending_queries.size() == 0 && expected_hits.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_hits.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        start = 1'b0;
        idle_cycles = 0;
        {i_box_min_x, i_box_min_y, i_box_min_z, i_box_max_x, i_box_max_y, i_box_max_z} = '0;
        {i_origin_x, i_origin_y, i_origin_z, i_direction_x, i_direction_y, i_direction_z} = '0;
    end

    always @(posedge i_clk) begin
        ray_query_t q;
        if (i_rst_n && start && !busy) begin
            expected_hits.push_back(predict_hit(pending_queries.pop_front()));
        end
        if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            start <= 1'b0;
        end else if (idle_allowed && $urandom_range(0, 19) == 0) begin
            idle_cycles <= $urandom_range(0, 15);
            start <= 1'b0;
        end else if (!i_rst_n || hold_for_drain || pending_queries.size() == 0) begin
            start <= 1'b0;
        end else begin
            q = pending_queries[0];
            start <= 1'b1;
            i_box_min_x <= q.bmin[0];
            i_box_min_y <= q.bmin[1];
            i_box_min_z <= q.bmin[2];
            i_box_max_x <= q.bmax[0];
            i_box_max_y <= q.bmax[1];
            i_box_max_z <= q.bmax[2];
            i_origin_x <= q.org[0];
            i_origin_y <= q.org[1];
            i_origin_z <= q.org[2];
            i_direction_x <= q.dir[0];
            i_direction_y <= q.dir[1];
            i_direction_z <= q.dir[2];
        end
    end

    always @(posedge i_clk) begin
        hit_result_t want;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if ((start && !busy) || o_strobe)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
            if (o_strobe) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch("result strobe with no request outstanding");
                end else begin
                    want = expected_hits.pop_front();
                    if (o_hit !== want.hit)
                        report_mismatch($sformatf("hit %b, expected %b", o_hit, want.hit));
                    if (o_distance !== want.distance)
                        report_mismatch($sformatf("distance %h, expected %h",
                                                  o_distance, want.distance));
                end
            end
        end
    end

endmodule

[filelist.f]
rtl/core/rbs_pkg.sv
rtl/core/rbs_div.sv
rtl/core/rbs_lane.sv
rtl/core/rbs_merge.sv
rtl/core/ray_box_slab_intersection.sv
tb/ray_box_slab_intersection_test.sv
